/* hdl/srt_pkg.sv */
// Shared types and constants for the trapezoidal stepper ramp generator.
// Used by the channel interfaces, the register block, the offset unit and the top level.
package srt_pkg;

  localparam int unsigned PER_W   = 8;
  localparam int unsigned STEPS_W = 16;
  localparam int unsigned TAKEN_W = 17;

  localparam logic [PER_W-1:0] START_RST  = 8'd240;
  localparam logic [PER_W-1:0] CRUISE_RST = 8'd120;

  localparam logic [0:0] REG_START  = 1'b0;
  localparam logic [0:0] REG_CRUISE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [STEPS_W-1:0] move_steps;
    logic               move_direction;
  } in_t;

  typedef struct packed {
    logic               step_level;
    logic               direction_level;
    logic               moving;
    logic               move_done;
    logic [TAKEN_W-1:0] steps_taken;
    logic [PER_W-1:0]   period_now;
  } out_t;

  // start minus a signed offset, clipped to the period range
  function automatic logic [PER_W-1:0] sat_period(logic [PER_W-1:0] start,
                                                   logic [PER_W-1:0] ofs,
                                                   logic             neg);
    logic [PER_W+1:0] sum;
    sum = neg ? ({2'b00, start} + {2'b00, ofs}) : ({2'b00, start} - {2'b00, ofs});
    if (sum[PER_W+1]) begin
      return '0;
    end else if (sum[PER_W]) begin
      return '1;
    end
    return sum[PER_W-1:0];
  endfunction

endpackage

/* hdl/srt_if.sv */
// Valid/ready channel interfaces for the ramp generator's input and result streams.
// Depends on srt_pkg for the payload structs.
interface srt_in_if;
  logic         valid;
  logic         ready;
  srt_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srt_out_if;
  logic          valid;
  logic          ready;
  srt_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/srt_cfg.sv */
// APB-style register block holding the start and cruise periods.
// Depends on srt_pkg for reset values and register indexes.
module srt_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [srt_pkg::PER_W-1:0] start_period_o,
  output logic [srt_pkg::PER_W-1:0] cruise_period_o
);

  logic [srt_pkg::PER_W-1:0] start_q;
  logic [srt_pkg::PER_W-1:0] cruise_q;
  logic [0:0]                idx;
  logic                      wr_en;

  assign idx    = paddr[2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= srt_pkg::START_RST;
      cruise_q <= srt_pkg::CRUISE_RST;
    end else if (wr_en) begin
      unique case (idx)
        srt_pkg::REG_START:  start_q  <= pwdata[srt_pkg::PER_W-1:0];
        srt_pkg::REG_CRUISE: cruise_q <= pwdata[srt_pkg::PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      srt_pkg::REG_START:  prdata[srt_pkg::PER_W-1:0] = start_q;
      srt_pkg::REG_CRUISE: prdata[srt_pkg::PER_W-1:0] = cruise_q;
      default: ;
    endcase
  end

  assign start_period_o  = start_q;
  assign cruise_period_o = cruise_q;

endmodule

/* hdl/srt_ofs.sv */
// Bit-serial ramp offset unit: mag * num / den, one multiplier bit then one quotient bit a cycle.
// Depends on srt_pkg for the period width; num never exceeds den, so the quotient fits a period.
module srt_ofs #(
  parameter int unsigned W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [srt_pkg::PER_W-1:0] mag_i,
  input  logic [W-1:0]              num_i,
  input  logic [W-1:0]              den_i,
  output logic                      done_o,
  output logic [srt_pkg::PER_W-1:0] quo_o
);

  localparam int unsigned PW = srt_pkg::PER_W;
  localparam int unsigned AW = W + PW;
  localparam int unsigned CW = $clog2(PW);
  localparam logic [CW-1:0] LAST = CW'(PW - 1);

  logic          busy_q, phase_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] mag_q, quo_q;
  logic [W-1:0]  num_q;
  logic [AW-1:0] acc_q, den_q;
  logic [AW-1:0] acc_sh, diff;

  assign acc_sh = {acc_q[AW-2:0], 1'b0} + (mag_q[PW-1] ? AW'(num_q) : '0);
  assign diff   = acc_q - den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          phase_q <= 1'b1;
          if (phase_q) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mag_q <= mag_i;
      num_q <= num_i;
      den_q <= {1'b0, den_i, {(PW-1){1'b0}}};
    end else if (busy_q) begin
      if (!phase_q) begin
        acc_q <= acc_sh;
        mag_q <= {mag_q[PW-2:0], 1'b0};
      end else begin
        if (acc_q >= den_q) begin
          acc_q <= diff;
          quo_q <= {quo_q[PW-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[PW-2:0], 1'b0};
        end
        den_q <= {1'b0, den_q[AW-1:1]};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* hdl/stepper_trapezoid_ramp.sv */
// Trapezoidal stepper ramp generator. One input item is taken at a time and gives one result.
// A tick while idle goes straight to S_OUT; a start or tick in cruise or on a zero-length ramp
// passes through S_CALC and S_UPD first; a tick or start on a ramp also waits in S_WAIT for the
// bit-serial offset unit (shift-add multiply, then restoring divide). The result sits in an output
// register, so the next item is taken while it waits. Depends on srt_pkg, srt_if, srt_cfg, srt_ofs.
module stepper_trapezoid_ramp #(
  parameter int unsigned STEP_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srt_in_if.sink     in_i,
  srt_out_if.source  out_o,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  localparam int unsigned SB = STEP_BITS;
  localparam int unsigned PW = srt_pkg::PER_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state_q;
  logic          is_tick_q;
  logic [PW-1:0] tick_q, period_q;
  logic [SB:0]   toggle_q, shown_q;
  logic [SB-1:0] target_q;
  logic          pulse_q, active_q, dir_q, done_q;
  logic          out_valid_q;
  logic          start_go_q;
  srt_pkg::out_t out_data_q;

  logic [PW-1:0] start_p, cruise_p;
  logic          ofs_start, ofs_done;
  logic [PW-1:0] ofs_quo, mag;
  logic          neg;
  logic [SB-1:0] num_q, den_q;
  logic [SB-1:0] c_sat, q_len, h_pt;
  logic [SB+1:0] tri_n;
  logic [SB-1:0] num_c, den_c;
  logic          in_cruise;
  logic [SB:0]   toggle_inc;
  logic          load_out;

  srt_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start_period_o (start_p),
    .cruise_period_o(cruise_p)
  );

  srt_ofs #(.W(SB)) u_ofs (
    .clk_i, .rst_ni,
    .start_i(ofs_start),
    .mag_i  (mag),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (ofs_done),
    .quo_o  (ofs_quo)
  );

  assign neg = start_p < cruise_p;
  assign mag = neg ? (cruise_p - start_p) : (start_p - cruise_p);

  always_comb begin
    c_sat     = (toggle_q > {1'b0, target_q}) ? target_q : toggle_q[SB-1:0];
    q_len     = target_q >> 2;
    tri_n     = {2'b00, target_q} + {1'b0, target_q, 1'b0};
    h_pt      = tri_n[SB+1:2];
    in_cruise = (c_sat > q_len) && (c_sat <= h_pt);
    if (c_sat <= q_len) begin
      num_c = c_sat;
      den_c = q_len;
    end else begin
      num_c = target_q - c_sat;
      den_c = target_q - h_pt;
    end
  end

  assign toggle_inc = toggle_q + 1'b1;
  assign ofs_start  = (state_q == S_WAIT) && start_go_q;
  assign load_out   = (state_q == S_OUT) && (!out_valid_q || out_o.ready);
  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      is_tick_q   <= 1'b0;
      tick_q      <= '0;
      toggle_q    <= '0;
      target_q    <= '0;
      pulse_q     <= 1'b0;
      active_q    <= 1'b0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
      start_go_q  <= 1'b0;
    end else begin
      start_go_q <= 1'b0;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            if (in_i.data.kind) begin
              target_q  <= SB'(in_i.data.move_steps);
              dir_q     <= in_i.data.move_direction;
              toggle_q  <= '0;
              tick_q    <= '0;
              pulse_q   <= 1'b0;
              active_q  <= 1'b1;
              is_tick_q <= 1'b0;
              state_q   <= S_CALC;
            end else if (active_q) begin
              is_tick_q <= 1'b1;
              state_q   <= S_CALC;
            end else begin
              is_tick_q <= 1'b0;
              state_q   <= S_OUT;
            end
          end
        end
        S_CALC: begin
          if (in_cruise || den_c == '0) begin
            state_q <= S_UPD;
          end else begin
            start_go_q <= 1'b1;
            state_q    <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (ofs_done) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (is_tick_q) begin
            if (tick_q >= period_q) begin
              tick_q  <= '0;
              pulse_q <= ~pulse_q;
              if (toggle_inc > {1'b0, target_q}) begin
                active_q <= 1'b0;
                toggle_q <= '0;
              end else begin
                toggle_q <= toggle_inc;
              end
            end else begin
              tick_q <= tick_q + 1'b1;
            end
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        period_q <= '0;
        shown_q  <= '0;
        done_q   <= 1'b0;
      end
      S_CALC: begin
        num_q <= num_c;
        den_q <= den_c;
        if (in_cruise) begin
          period_q <= cruise_p;
        end else if (den_c == '0) begin
          period_q <= start_p;
        end
      end
      S_WAIT: begin
        if (ofs_done) begin
          period_q <= srt_pkg::sat_period(start_p, ofs_quo, neg);
        end
      end
      S_UPD: begin
        if (is_tick_q && tick_q >= period_q) begin
          shown_q <= toggle_inc;
          done_q  <= toggle_inc > {1'b0, target_q};
        end else if (is_tick_q) begin
          shown_q <= toggle_q;
        end
      end
      S_OUT: begin
        if (load_out) begin
          out_data_q.step_level      <= pulse_q;
          out_data_q.direction_level <= dir_q;
          out_data_q.moving          <= active_q;
          out_data_q.move_done       <= done_q;
          out_data_q.steps_taken     <= srt_pkg::TAKEN_W'(shown_q);
          out_data_q.period_now      <= period_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
